/* rtl/core/gwat_pkg.sv */
// Shared constants and types for the Gray-ordered Walsh angle transform.
package gwat_pkg;

    localparam int MaxLogSize = 6;
    localparam int AddrW      = MaxLogSize;
    localparam int Depth      = 1 << MaxLogSize;
    localparam int CountW     = MaxLogSize + 1;
    localparam int AngleW     = 32;
    localparam int AccW       = AngleW + MaxLogSize;
    localparam int LogW       = 3;
    localparam int CtlW       = 3;

    // Commands from the sequencer to the angle store and accumulator.
    typedef struct packed {
        logic                     wr_en;
        logic [AddrW-1:0]         wr_addr;
        logic [AngleW-1:0]        wr_data;
        logic                     rd_en;
        logic [AddrW-1:0]         rd_addr;
        logic                     rd_neg;
        logic                     rd_first;
    } t_store_cmd;

endpackage

/* rtl/core/gwat_if.sv */
// Channel interfaces: input angles, output results and the configuration write.
interface gwat_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [gwat_pkg::AngleW-1:0]   angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface gwat_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [gwat_pkg::AngleW-1:0]   theta;
    logic        [gwat_pkg::CtlW-1:0]     control_position;
    logic                                 last;

    modport source (output valid, output theta, output control_position, output last,
                    input ready);
    modport sink   (input valid, input theta, input control_position, input last,
                    output ready);
endinterface

interface gwat_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [gwat_pkg::LogW-1:0]     log_size;

    modport source (output valid, output log_size, input ready);
    modport sink   (input valid, input log_size, output ready);
endinterface

/* rtl/core/gray_walsh_angle_transform.sv */
// Top level of the Gray-ordered Walsh angle transform.
// A set of N = 2^log_size angles (log_size saturates at 6) loads into the angle store at one angle
// per cycle while no register write is offered. Each result then takes N store reads, a drain state
// to finish the accumulation and an emit state to load the output register, which waits while the
// previous result is stalled.
// Synchronous active-low reset clears the sequencer, count, log_size and output valid, not the store memory.
module gray_walsh_angle_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gwat_cfg_if.sink    i_cfg,
    gwat_in_if.sink     i_in,
    gwat_out_if.source  o_out
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]                             r_state;
    logic [gwat_pkg::LogW-1:0]              r_k;
    logic [gwat_pkg::CountW-1:0]            r_count;
    logic [gwat_pkg::CountW-1:0]            w_count_inc;
    logic [gwat_pkg::AddrW-1:0]             r_i;
    logic [gwat_pkg::AddrW-1:0]             r_j;
    logic                                   r_out_vld;
    logic [gwat_pkg::AngleW-1:0]            r_theta;
    logic [gwat_pkg::CtlW-1:0]              r_ctl;
    logic                                   r_last;

    logic [gwat_pkg::CountW-1:0]            w_n;
    logic [gwat_pkg::AddrW-1:0]             w_mask;
    logic                                   w_last_j;
    logic                                   w_last_i;
    logic [gwat_pkg::AddrW-1:0]             w_gray_i;
    logic [gwat_pkg::AddrW-1:0]             w_next_i;
    logic [gwat_pkg::AddrW-1:0]             w_diff;
    logic [gwat_pkg::CtlW-1:0]              w_pos;
    logic [gwat_pkg::CtlW-1:0]              w_ctl;
    logic                                   w_in_xfer;
    logic                                   w_cfg_xfer;
    logic                                   w_out_free;
    logic signed [gwat_pkg::AccW-1:0]       w_acc;
    logic signed [gwat_pkg::AccW-1:0]       w_shifted;
    gwat_pkg::t_store_cmd                   w_cmd;

    function automatic logic [gwat_pkg::AddrW-1:0] gray(input logic [gwat_pkg::AddrW-1:0] v);
        gray = v ^ (v >> 1);
    endfunction

    // A register transfer takes precedence over an angle offered in the same cycle.
    assign i_cfg.ready = (r_state == S_LOAD);
    assign i_in.ready  = (r_state == S_LOAD) && !i_cfg.valid;
    assign w_cfg_xfer  = i_cfg.valid && i_cfg.ready;
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_vld || o_out.ready;

    assign w_n         = gwat_pkg::CountW'(1) << r_k;
    assign w_mask      = w_n[gwat_pkg::AddrW-1:0] - gwat_pkg::AddrW'(1);
    assign w_last_j    = (r_j == w_mask);
    assign w_last_i    = (r_i == w_mask);
    assign w_count_inc = r_count + gwat_pkg::CountW'(1);
    assign w_gray_i    = gray(r_i);
    assign w_next_i    = (r_i + gwat_pkg::AddrW'(1)) & w_mask;
    assign w_diff      = w_gray_i ^ gray(w_next_i);

    // The neighbouring Gray codes differ in exactly one bit; find it.
    always_comb begin
        w_pos = '0;
        for (int b = gwat_pkg::AddrW - 1; b >= 0; b--) begin
            if (w_diff[b]) begin
                w_pos = gwat_pkg::CtlW'(b);
            end
        end
        w_ctl = (r_k == '0) ? '0 : r_k - gwat_pkg::CtlW'(1) - w_pos;
    end

    always_comb begin
        w_cmd          = '0;
        w_cmd.wr_en    = w_in_xfer;
        w_cmd.wr_addr  = r_count[gwat_pkg::AddrW-1:0];
        w_cmd.wr_data  = i_in.angle;
        w_cmd.rd_en    = (r_state == S_READ);
        w_cmd.rd_addr  = r_j;
        w_cmd.rd_neg   = ^(r_j & w_gray_i);
        w_cmd.rd_first = (r_j == '0);
    end

    gwat_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_acc   (w_acc)
    );

    assign w_shifted = w_acc >>> r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_k       <= '0;
            r_count   <= '0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_in_xfer) begin
                        if (w_count_inc == w_n) begin
                            r_count <= '0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_READ;
                        end else begin
                            r_count <= w_count_inc;
                        end
                    end
                end
                S_READ: begin
                    r_j <= r_j + gwat_pkg::AddrW'(1);
                    if (w_last_j) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_j       <= '0;
                        if (w_last_i) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + gwat_pkg::AddrW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
            // A new set size drops any partly loaded set.
            if (w_cfg_xfer) begin
                r_k     <= (i_cfg.log_size > gwat_pkg::LogW'(gwat_pkg::MaxLogSize))
                           ? gwat_pkg::LogW'(gwat_pkg::MaxLogSize) : i_cfg.log_size;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_theta <= w_shifted[gwat_pkg::AngleW-1:0];
            r_ctl   <= w_ctl;
            r_last  <= w_last_i;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.theta            = r_theta;
    assign o_out.control_position = r_ctl;
    assign o_out.last             = r_last;

endmodule

/* rtl/core/gwat_store.sv */
// Angle store memory with a signed accumulator behind its registered read port.
module gwat_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gwat_pkg::t_store_cmd                i_cmd,
    output logic signed [gwat_pkg::AccW-1:0]    o_acc
);

    logic [gwat_pkg::AngleW-1:0]        r_mem [gwat_pkg::Depth];
    logic [gwat_pkg::AngleW-1:0]        r_rdata;
    logic                               r_rd_vld;
    logic                               r_rd_neg;
    logic                               r_rd_first;
    logic signed [gwat_pkg::AccW-1:0]   r_acc;
    logic signed [gwat_pkg::AccW-1:0]   n_acc;
    logic signed [gwat_pkg::AccW-1:0]   w_ext;
    logic signed [gwat_pkg::AccW-1:0]   w_term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_addr];
        end
        r_rd_neg   <= i_cmd.rd_neg;
        r_rd_first <= i_cmd.rd_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_comb begin
        w_ext  = {{(gwat_pkg::AccW - gwat_pkg::AngleW){r_rdata[gwat_pkg::AngleW-1]}}, r_rdata};
        w_term = r_rd_neg ? -w_ext : w_ext;
        n_acc  = r_rd_first ? w_term : r_acc + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/core/gwat_chk.sv */
// Port-level checker for the transform, bound to the top level.
module gwat_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [gwat_pkg::AngleW-1:0]     i_out_theta,
    input  logic [gwat_pkg::CtlW-1:0]       i_out_ctl,
    input  logic                            i_out_last
);

    // A result waiting for its transfer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_theta) && $stable(i_out_ctl)
            && $stable(i_out_last))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // The final step wraps back to Gray code zero through the top control.
    a_last_ctl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_ctl == '0)
        else $error("final result has a non-zero control position");

    a_ctl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_ctl < gwat_pkg::CtlW'(gwat_pkg::MaxLogSize))
        else $error("control position out of range");

endmodule

bind gray_walsh_angle_transform gwat_chk u_gwat_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_theta (o_out.theta),
    .i_out_ctl   (o_out.control_position),
    .i_out_last  (o_out.last)
);

/* sim/testbench.sv */
// Self-checking testbench for the Gray-ordered Walsh angle transform.
module testbench;

    localparam int CycleLimit   = 4_000_000;
    localparam int SettleCycles = 150;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic                               drain;
        logic signed [gwat_pkg::AngleW-1:0] angle;
    } t_angle_slot;

    typedef struct packed {
        logic signed [gwat_pkg::AngleW-1:0] theta;
        logic        [gwat_pkg::CtlW-1:0]   ctl;
        logic                               last;
    } t_transform_result;

    logic clk = 1'b0;
    logic rst_n;

    gwat_cfg_if cfg_ch ();
    gwat_in_if  in_ch ();
    gwat_out_if out_ch ();

    gray_walsh_angle_transform dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_angle_slot       angle_queue[$];
    t_transform_result expected_theta[$];

    logic signed [gwat_pkg::AngleW-1:0] angle_mem [gwat_pkg::Depth];
    logic        [gwat_pkg::LogW-1:0]   model_log_size;
    int                                 model_count;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  failures;
    int  cycle_count;
    logic in_taken;
    logic cfg_taken;

    always #2 clk = ~clk;

    // Accumulates one angle into the set; a completed set yields its transform.
    task automatic load_angle(input logic signed [gwat_pkg::AngleW-1:0] a);
        int k, n, i, j, g, nxt, diff, p;
        longint acc;
        t_transform_result r;
        k = (model_log_size > gwat_pkg::MaxLogSize) ? gwat_pkg::MaxLogSize
                                                     : int'(model_log_size);
        n = 1 << k;
        angle_mem[model_count % gwat_pkg::Depth] = a;
        model_count = model_count + 1;
        if (model_count < n)
            return;
        model_count = 0;
        for (i = 0; i < n; i++) begin
            g    = i ^ (i >> 1);
            nxt  = (i + 1) & (n - 1);
            diff = g ^ (nxt ^ (nxt >> 1));
            acc  = 0;
            for (j = 0; j < n; j++) begin
                if (^(j & g))
                    acc = acc - longint'(angle_mem[j]);
                else
                    acc = acc + longint'(angle_mem[j]);
            end
            p = 0;
            while (p < 31 && ((diff >> p) & 1) == 0)
                p++;
            r.theta = gwat_pkg::AngleW'(acc >>> k);
            r.ctl   = (k > 0) ? gwat_pkg::CtlW'(k - 1 - p) : '0;
            r.last  = (i == n - 1);
            expected_theta.insert(expected_theta.size(), r);
        end
    endtask

    task automatic check_result();
        t_transform_result want;
        if (expected_theta.size() == 0) begin
            $error("unexpected result: theta %0d control_position %0d last %0b",
                   out_ch.theta, out_ch.control_position, out_ch.last);
            failures++;
            return;
        end
        want = expected_theta.pop_front();
        if (out_ch.theta !== want.theta) begin
            $error("theta: expected %0d, got %0d", want.theta, out_ch.theta);
            failures++;
        end
        if (out_ch.control_position !== want.ctl) begin
            $error("control_position: expected %0d, got %0d", want.ctl,
                   out_ch.control_position);
            failures++;
        end
        if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            failures++;
        end
    endtask

    always @(posedge clk) begin : monitor
        in_taken  <= rst_n && in_ch.valid && in_ch.ready;
        cfg_taken <= rst_n && cfg_ch.valid && cfg_ch.ready;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready)
                check_result();
            if (cfg_ch.valid && cfg_ch.ready) begin
                model_log_size = cfg_ch.log_size;
                model_count    = 0;
            end
            if (in_ch.valid && in_ch.ready)
                load_angle(in_ch.angle);
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk) begin : driver
        logic gap;
        gap = ($urandom_range(99) < send_idle_pct);
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!in_ch.valid || in_taken) begin
                if (angle_queue.size() != 0 && angle_queue[0].drain) begin
                    // Hold the sender back until every outstanding result has come.
                    if (expected_theta.size() == 0)
                        angle_queue.delete(0);
                    in_ch.valid <= 1'b0;
                end else if (angle_queue.size() != 0 && !gap) begin
                    in_ch.valid <= 1'b1;
                    in_ch.angle <= angle_queue[0].angle;
                    angle_queue.delete(0);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (angle_queue.size() != 0 || in_ch.valid || expected_theta.size() != 0);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_log_size(input logic [gwat_pkg::LogW-1:0] v);
        wait_quiet();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.log_size <= v;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 60 : (mode == IDLE_BOTH) ? 14 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 60 : (mode == IDLE_BOTH) ? 14 : 0;
    endtask

    task automatic queue_slot(input logic drain, input logic [gwat_pkg::AngleW-1:0] a);
        t_angle_slot slot;
        slot.drain = drain;
        slot.angle = a;
        angle_queue.insert(angle_queue.size(), slot);
    endtask

    task automatic push_angle(input logic [gwat_pkg::AngleW-1:0] a);
        queue_slot(1'b0, a);
    endtask

    function automatic logic [gwat_pkg::AngleW-1:0] pick_angle();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return gwat_pkg::AngleW'(int'($urandom_range(255)) - 128);
            default: return $urandom();
        endcase
    endfunction

    // Whole sets of random angles, sometimes followed by a short partial set that
    // the next register transfer discards.
    task automatic run_phase(input logic [gwat_pkg::LogW-1:0] v, input t_idle_mode mode);
        int k, n, sets, s, i;
        write_log_size(v);
        set_idling(mode);
        k    = (v > gwat_pkg::MaxLogSize) ? gwat_pkg::MaxLogSize : int'(v);
        n    = 1 << k;
        sets = (8 >> k) > 1 ? (8 >> k) : 1;
        for (s = 0; s < sets; s++) begin
            for (i = 0; i < n; i++)
                push_angle(pick_angle());
            if (s == 0 && (mode == IDLE_NONE || $urandom_range(1) == 1))
                queue_slot(1'b1, '0);
        end
        if (n > 1 && $urandom_range(1) == 1)
            repeat ($urandom_range(1, (n > 4) ? 3 : n - 1)) push_angle(pick_angle());
    endtask

    initial begin
        cfg_ch.valid    = 1'b0;
        cfg_ch.log_size = '0;
        in_ch.valid     = 1'b0;
        in_ch.angle     = '0;
        out_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        model_log_size  = '0;
        model_count     = 0;
        failures        = 0;
        cycle_count     = 0;
        in_taken        = 1'b0;
        cfg_taken       = 1'b0;
        foreach (angle_mem[a]) angle_mem[a] = '0;
        set_idling(IDLE_NONE);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Single-angle sets pass each angle straight through.
        write_log_size(3'd0);
        push_angle(32'h7FFF_FFFF);
        push_angle(32'h8000_0000);
        push_angle(32'h0000_0000);
        push_angle(32'hFFFF_FFFF);
        push_angle(32'h0000_0001);

        write_log_size(3'd1);
        push_angle(32'h7FFF_FFFF);
        push_angle(32'h8000_0000);
        push_angle(32'h8000_0000);
        push_angle(32'h8000_0000);
        push_angle(32'h7FFF_FFFF);
        push_angle(32'h7FFF_FFFF);

        // Full-scale negative set, then a partial set dropped by the next write.
        write_log_size(3'd2);
        repeat (4) push_angle(32'h8000_0000);
        push_angle(32'h7FFF_FFFF);
        push_angle(32'h0000_0001);

        write_log_size(3'd6);
        push_angle(32'hFFFF_FFFF);
        push_angle(32'h8000_0000);

        run_phase(3'd1, IDLE_NONE);
        run_phase(3'd3, IDLE_SEND);
        run_phase(3'd0, IDLE_RECV);
        run_phase(3'd2, IDLE_BOTH);
        // A value above the maximum saturates to the largest set.
        run_phase(3'd7, IDLE_SEND);
        run_phase(3'd4, IDLE_RECV);
        run_phase(3'd1, IDLE_BOTH);

        wait_quiet();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/gwat_pkg.sv
rtl/core/gwat_if.sv
rtl/core/gwat_store.sv
rtl/core/gray_walsh_angle_transform.sv
rtl/core/gwat_chk.sv
sim/testbench.sv
